// ===== design/u8d_pkg.sv =====
// Package for the UTF-8 to UTF-32 decoder: shared widths, lead byte ranges
// and the result struct. No dependencies.
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 31;
    localparam int unsigned PEND_W = 3;

    // Lead byte ranges, extended six-byte form
    localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF7;
    localparam logic [BYTE_W-1:0] LEAD5_LO = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD5_HI = 8'hFB;
    localparam logic [BYTE_W-1:0] LEAD6_LO = 8'hFC;
    localparam logic [BYTE_W-1:0] LEAD6_HI = 8'hFD;

    // Continuation bytes are 10xxxxxx
    localparam logic [1:0] CONT_TAG = 2'b10;

    localparam logic [PEND_W-1:0] PEND_MAX = 3'd5;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            bad_sequence;
    } t_result;

    typedef struct packed {
        logic [CP_W-1:0]   partial;
        logic [PEND_W-1:0] pending;
    } t_state;

endpackage

// ===== design/u8d_step.sv =====
// One decode step: current state plus one byte gives the next state and an
// optional result. Pure combinational logic; depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_step (
    input  u8d_pkg::t_state              i_state,
    input  logic [u8d_pkg::BYTE_W-1:0]   i_byte,
    output u8d_pkg::t_state              o_state,
    output logic                         o_has_result,
    output u8d_pkg::t_result             o_result
);

    logic                          is_cont;
    logic [u8d_pkg::PEND_W-1:0]    k;
    logic [u8d_pkg::CP_W-1:0]      shifted;
    logic [u8d_pkg::CP_W-1:0]      merged;

    assign is_cont = (i_byte[7:6] == u8d_pkg::CONT_TAG);

    // Continuations left after this byte; six-bit group lands at 6*k
    always_comb begin
        k = i_state.pending - 3'd1;
        if (k > 3'd4) begin
            k = 3'd4;
        end
    end

    always_comb begin
        case (k)
            3'd0:    shifted = {25'd0, i_byte[5:0]};
            3'd1:    shifted = {19'd0, i_byte[5:0], 6'd0};
            3'd2:    shifted = {13'd0, i_byte[5:0], 12'd0};
            3'd3:    shifted = {7'd0, i_byte[5:0], 18'd0};
            default: shifted = {1'b0, i_byte[5:0], 24'd0};
        endcase
    end

    assign merged = i_state.partial | shifted;

    always_comb begin
        o_state      = i_state;
        o_has_result = 1'b0;
        o_result     = '0;
        if (i_state.pending != '0) begin
            if (is_cont) begin
                o_state.pending = k;
                if (k == '0) begin
                    o_state.partial     = '0;
                    o_has_result        = 1'b1;
                    o_result.code_point = merged;
                end else begin
                    o_state.partial = merged;
                end
            end else begin
                // missing continuation: drop sequence and this byte
                o_state               = '0;
                o_has_result          = 1'b1;
                o_result.bad_sequence = 1'b1;
            end
        end else begin
            if (i_byte inside {[u8d_pkg::LEAD6_LO:u8d_pkg::LEAD6_HI]}) begin
                o_state.partial = {i_byte[0], 30'd0};
                o_state.pending = 3'd5;
            end else if (i_byte inside {[u8d_pkg::LEAD5_LO:u8d_pkg::LEAD5_HI]}) begin
                o_state.partial = {5'd0, i_byte[1:0], 24'd0};
                o_state.pending = 3'd4;
            end else if (i_byte inside {[u8d_pkg::LEAD4_LO:u8d_pkg::LEAD4_HI]}) begin
                o_state.partial = {10'd0, i_byte[2:0], 18'd0};
                o_state.pending = 3'd3;
            end else if (i_byte inside {[u8d_pkg::LEAD3_LO:u8d_pkg::LEAD3_HI]}) begin
                o_state.partial = {15'd0, i_byte[3:0], 12'd0};
                o_state.pending = 3'd2;
            end else if (i_byte inside {[u8d_pkg::LEAD2_LO:u8d_pkg::LEAD2_HI]}) begin
                o_state.partial = {20'd0, i_byte[4:0], 6'd0};
                o_state.pending = 3'd1;
            end else begin
                // ASCII, stray continuation, 0xFE, 0xFF pass through
                o_has_result        = 1'b1;
                o_result.code_point = {23'd0, i_byte};
            end
        end
    end

endmodule

// ===== design/utf8_to_utf32_decoder_top.sv =====
// Top level of the UTF-8 to UTF-32 decoder: state registers, decode step and
// a two-entry output stage. Depends on u8d_pkg and u8d_step.
`timescale 1ns / 1ps

//  channel | valid   | ready   | payload
//  --------+---------+---------+-----------------------------------
//  input   | i_valid | o_ready | i_in_byte
//  result  | o_valid | i_ready | o_code_point, o_bad_sequence
//
// One byte per cycle while o_ready is high. The decode step runs on the
// accepted byte in the same cycle and its result is registered in the
// output register, or in the skid register while that one is held. An
// output register plus a skid register keep input flowing while the
// consumer stalls; o_ready drops only when both hold a result. Reset
// returns the decoder to idle with an empty output stage.

module utf8_to_utf32_decoder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [u8d_pkg::BYTE_W-1:0]   i_in_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [u8d_pkg::CP_W-1:0]     o_code_point,
    output logic                         o_bad_sequence
);

    u8d_pkg::t_state  r_state;
    u8d_pkg::t_state  n_state;
    u8d_pkg::t_result step_result;
    logic             step_has_result;

    u8d_pkg::t_result r_out;
    u8d_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;

    logic accept;
    logic push;
    logic pop;

    u8d_step u_step (
        .i_state      (r_state),
        .i_byte       (i_in_byte),
        .o_state      (n_state),
        .o_has_result (step_has_result),
        .o_result     (step_result)
    );

    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;
    assign push    = accept && step_has_result;
    assign pop     = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= step_result;
            end
        end else if (push) begin
            r_skid <= step_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_code_point   = r_out.code_point;
    assign o_bad_sequence = r_out.bad_sequence;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_sequence |-> o_code_point == '0)
        else $error("error result carries a nonzero code point");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pending <= u8d_pkg::PEND_MAX)
        else $error("continuation count out of range");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && step_has_result |=> r_state.partial == '0)
        else $error("partial value not cleared after a result");

endmodule

// ===== verif/u8d_checker.sv =====
// Checker for the UTF-8 to UTF-32 decoder: watches both channels, predicts
// each decoded result and compares it with what the block returns. Uses u8d_pkg.
`timescale 1ns / 1ps

module u8d_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [u8d_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [u8d_pkg::CP_W-1:0]     i_code_point,
    input  logic                         i_bad_sequence,
    output int                           o_fail_count,
    output int                           o_outstanding
);

    logic [u8d_pkg::CP_W-1:0]   partial_cp;
    logic [u8d_pkg::PEND_W-1:0] cont_left;
    u8d_pkg::t_result           decoded_q[$];
    u8d_pkg::t_result           new_res;
    u8d_pkg::t_result           want;

    initial o_fail_count = 0;

    // Advances the decode state by one byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [u8d_pkg::BYTE_W-1:0] b,
                                       output u8d_pkg::t_result res);
        logic [u8d_pkg::PEND_W-1:0] k;
        res = '0;
        if (cont_left != '0) begin
            if (b[7:6] == u8d_pkg::CONT_TAG) begin
                k = cont_left - 1'b1;
                partial_cp = partial_cp | ({25'd0, b[5:0]} << (6 * k));
                cont_left = k;
                if (k == '0) begin
                    res.code_point = partial_cp;
                    partial_cp = '0;
                    return 1'b1;
                end
                return 1'b0;
            end
            // missing continuation: drop everything, this byte too
            partial_cp = '0;
            cont_left = '0;
            res.bad_sequence = 1'b1;
            return 1'b1;
        end
        if (b >= u8d_pkg::LEAD6_LO && b <= u8d_pkg::LEAD6_HI) begin
            partial_cp = {b[0], 30'd0};
            cont_left = 3'd5;
        end else if (b >= u8d_pkg::LEAD5_LO && b <= u8d_pkg::LEAD5_HI) begin
            partial_cp = {5'd0, b[1:0], 24'd0};
            cont_left = 3'd4;
        end else if (b >= u8d_pkg::LEAD4_LO && b <= u8d_pkg::LEAD4_HI) begin
            partial_cp = {10'd0, b[2:0], 18'd0};
            cont_left = 3'd3;
        end else if (b >= u8d_pkg::LEAD3_LO && b <= u8d_pkg::LEAD3_HI) begin
            partial_cp = {15'd0, b[3:0], 12'd0};
            cont_left = 3'd2;
        end else if (b >= u8d_pkg::LEAD2_LO && b <= u8d_pkg::LEAD2_HI) begin
            partial_cp = {20'd0, b[4:0], 6'd0};
            cont_left = 3'd1;
        end else begin
            res.code_point = {23'd0, b};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            partial_cp = '0;
            cont_left = '0;
            decoded_q.delete();
            o_outstanding = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result code_point %h bad_sequence %b",
                             $time, i_code_point, i_bad_sequence);
                    o_fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_code_point !== want.code_point) begin
                        $display("%0t: code_point expected %h actual %h",
                                 $time, want.code_point, i_code_point);
                        o_fail_count++;
                    end
                    if (i_bad_sequence !== want.bad_sequence) begin
                        $display("%0t: bad_sequence expected %b actual %b",
                                 $time, want.bad_sequence, i_bad_sequence);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (decode_byte(i_in_byte, new_res))
                    decoded_q = {decoded_q, new_res};
            end
            o_outstanding = decoded_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the UTF-8 to UTF-32 decoder: drives byte requests and
// result stalls, gives the verdict. Uses u8d_pkg, u8d_checker and the block.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_BYTES = 1425;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic [u8d_pkg::BYTE_W-1:0] i_in_byte = '0;
    logic                       i_ready = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic [u8d_pkg::CP_W-1:0]   o_code_point;
    logic                       o_bad_sequence;

    int fail_count;
    int outstanding;
    int bytes_sent = 0;
    bit steady = 1'b0;

    logic [u8d_pkg::BYTE_W-1:0] directed_bytes [25];

    utf8_to_utf32_decoder_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_point   (o_code_point),
        .o_bad_sequence (o_bad_sequence)
    );

    u8d_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_in_byte      (i_in_byte),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_code_point   (o_code_point),
        .i_bad_sequence (o_bad_sequence),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_400_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // consumer stalls ~22% of cycles outside the steady stretch
    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 22);
    end

    task automatic put_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
        while (!steady && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    function automatic logic [u8d_pkg::BYTE_W-1:0] cont_byte();
        logic [u8d_pkg::BYTE_W-1:0] r;
        r = 8'($urandom);
        return {u8d_pkg::CONT_TAG, r[5:0]};
    endfunction

    // lead byte of an n-byte sequence (n = 1 gives plain ASCII)
    function automatic logic [u8d_pkg::BYTE_W-1:0] lead_byte(input int unsigned n);
        logic [u8d_pkg::BYTE_W-1:0] r;
        r = 8'($urandom);
        case (n)
            1: return {1'b0, r[6:0]};
            2: return {3'b110, r[4:0]};
            3: return {4'b1110, r[3:0]};
            4: return {5'b11110, r[2:0]};
            5: return {6'b111110, r[1:0]};
            default: return {7'b1111110, r[0]};
        endcase
    endfunction

    // lead of length n, then keep continuations; a short one ends in a breaker
    task automatic put_sequence(input int unsigned n, input int unsigned keep);
        logic [u8d_pkg::BYTE_W-1:0] breaker;
        put_byte(lead_byte(n));
        repeat (keep) put_byte(cont_byte());
        if (keep < n - 1) begin
            do breaker = 8'($urandom); while (breaker[7:6] == u8d_pkg::CONT_TAG);
            put_byte(breaker);
        end
    endtask

    initial begin
        int unsigned pick;
        int unsigned n;

        directed_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFE, 8'hFF,
                           8'hDF, 8'hBF,
                           8'hE0, 8'h80, 8'h80,
                           8'hF8, 8'h80, 8'h80, 8'h80, 8'h80,
                           8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                           8'hF3, 8'h41,          // lead cut by ASCII
                           8'hC2, 8'hE2};         // lead cut by another lead

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_bytes[i]) put_byte(directed_bytes[i]);

        while (bytes_sent < $size(directed_bytes) + RANDOM_BYTES) begin
            steady = (bytes_sent >= 500 && bytes_sent < 800);
            pick = $urandom_range(99);
            n = $urandom_range(1, 6);
            if (pick < 70)
                put_sequence(n, n - 1);
            else if (pick < 85)
                put_sequence((n < 2) ? 2 : n, $urandom_range(0, ((n < 2) ? 2 : n) - 2));
            else
                put_byte(8'($urandom));
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/u8d_pkg.sv
design/u8d_step.sv
design/utf8_to_utf32_decoder_top.sv
verif/u8d_checker.sv
verif/tb_top.sv
